FILE: hdl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared types and constants of the lane shape unit: pixel levels, run type
// codes, shape codes and the queue status bundle.
// ----------------------------------------------------------------------------
package lsr_pkg;

   // gray levels that carry meaning
   localparam logic [7:0] LEVEL_BLACK = 8'd0;
   localparam logic [7:0] LEVEL_GRAY  = 8'd128;
   localparam logic [7:0] LEVEL_WHITE = 8'd255;

   // run type codes
   localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
   localparam logic [1:0] TYPE_BLACK   = 2'd1;
   localparam logic [1:0] TYPE_GRAY    = 2'd2;
   localparam logic [1:0] TYPE_WHITE   = 2'd3;

   // shape codes, also used for the movement between two rows
   localparam logic [1:0] SHAPE_NONE     = 2'd0;
   localparam logic [1:0] SHAPE_LEFT     = 2'd1;
   localparam logic [1:0] SHAPE_STRAIGHT = 2'd2;
   localparam logic [1:0] SHAPE_RIGHT    = 2'd3;

   localparam int unsigned MARGIN_W = 10;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd15;

   // row records held between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [1:0] pixel_type(input logic [7:0] level);
      logic [1:0] t;
      case (level)
         LEVEL_BLACK: t = TYPE_BLACK;
         LEVEL_GRAY:  t = TYPE_GRAY;
         LEVEL_WHITE: t = TYPE_WHITE;
         default:     t = TYPE_UNKNOWN;
      endcase
      return t;
   endfunction

endpackage

FILE: hdl/lsr_queue.sv
// ----------------------------------------------------------------------------
// lsr_queue
// Small register queue of finished row records between the pixel front end
// and the frame back end. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lsr_queue #(
   parameter int unsigned WIDTH = 12,
   parameter int unsigned DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output lsr_pkg::queue_status_type status
);
   import lsr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

FILE: hdl/lsr_front.sv
// ----------------------------------------------------------------------------
// lsr_front
// Pixel front end: tracks runs of equal value along a row, types each run,
// watches for the black white gray white black pattern and keeps the
// midpoint of the first gray run. Emits one row record at each row or frame end.
// ----------------------------------------------------------------------------
module lsr_front #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     pixel,
   input  logic                           row_end,
   input  logic                           frame_end,
   output logic                           push,
   output logic [$clog2(MAX_WIDTH)+1:0]   push_data
);
   import lsr_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam logic [2:0]  RUNS_FULL = 3'd4;

   typedef struct packed {
      logic [3:0][1:0]  window;   // [0] oldest finished run
      logic [2:0]       runs;
      logic             pattern;
      logic             gray_found;
      logic [COL_W-1:0] gray_mid;
   } run_state_type;

   function automatic run_state_type finish_run(
      input run_state_type    st,
      input logic [1:0]       t,
      input logic [COL_W-1:0] s,
      input logic [COL_W-1:0] e
   );
      run_state_type r;
      logic [COL_W:0] sum;
      r   = st;
      sum = {1'b0, s} + {1'b0, e};
      if (t == TYPE_GRAY && !st.gray_found) begin
         r.gray_found = 1'b1;
         r.gray_mid   = sum[COL_W:1];
      end
      if (st.runs >= RUNS_FULL && st.window[0] == TYPE_BLACK &&
          st.window[1] == TYPE_WHITE && st.window[2] == TYPE_GRAY &&
          st.window[3] == TYPE_WHITE && t == TYPE_BLACK) begin
         r.pattern = 1'b1;
      end
      r.window[0] = st.window[1];
      r.window[1] = st.window[2];
      r.window[2] = st.window[3];
      r.window[3] = t;
      if (st.runs < RUNS_FULL) begin
         r.runs = st.runs + 1'b1;
      end
      return r;
   endfunction

   logic [COL_W-1:0] column_ff, column_in;
   logic [7:0]       last_pixel_ff, last_pixel_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   run_state_type    run_ff, run_in;

   logic             end_row;
   logic             run_closes;
   logic [COL_W-1:0] start_now;
   run_state_type    run_mid, run_last;

   always_comb begin
      end_row    = row_end | frame_end;
      run_closes = (column_ff != '0) && (pixel != last_pixel_ff);

      // run that the new pixel ends, if any
      run_mid   = run_ff;
      start_now = run_start_ff;
      if (column_ff == '0) begin
         start_now = '0;
      end else if (run_closes) begin
         run_mid   = finish_run(run_ff, pixel_type(last_pixel_ff), run_start_ff,
                                column_ff - 1'b1);
         start_now = column_ff;
      end

      // row end also closes the run that holds this pixel
      run_last = finish_run(run_mid, pixel_type(pixel), start_now, column_ff);

      column_in     = column_ff;
      last_pixel_in = last_pixel_ff;
      run_start_in  = run_start_ff;
      run_in        = run_ff;
      if (accept) begin
         if (end_row) begin
            column_in     = '0;
            last_pixel_in = '0;
            run_start_in  = '0;
            run_in        = '0;
         end else begin
            if (column_ff < COL_W'(MAX_WIDTH - 1)) begin
               column_in = column_ff + 1'b1;
            end
            last_pixel_in = pixel;
            run_start_in  = start_now;
            run_in        = run_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         last_pixel_ff <= '0;
         run_start_ff  <= '0;
         run_ff        <= '0;
      end else begin
         column_ff     <= column_in;
         last_pixel_ff <= last_pixel_in;
         run_start_ff  <= run_start_in;
         run_ff        <= run_in;
      end
   end

   // record: pattern, midpoint (zero for a failed row), frame end
   assign push      = accept & end_row;
   assign push_data = {run_last.pattern,
                       run_last.pattern ? run_last.gray_mid : COL_W'(0),
                       frame_end};

endmodule

FILE: hdl/lsr_back.sv
// ----------------------------------------------------------------------------
// lsr_back
// Frame back end: counts rows and failed rows, follows the movement of the
// midpoint from one valid row to the next, and forms the row result and the
// frame verdict in the output register.
// ----------------------------------------------------------------------------
module lsr_back #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_ROWS  = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lsr_pkg::MARGIN_W-1:0]        margin,
   input  lsr_pkg::queue_status_type           q_status,
   input  logic [$clog2(MAX_WIDTH)+1:0]        q_data,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [$clog2(MAX_WIDTH)-1:0]        rsp_row_midpoint,
   output logic                                rsp_row_valid,
   output logic                                rsp_frame_done,
   output logic [1:0]                          rsp_shape
);
   import lsr_pkg::*;

   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned RC_W   = $clog2(MAX_ROWS + 1);
   localparam int unsigned PROD_W = RC_W + 4;
   localparam int unsigned CMP_W  = (COL_W > MARGIN_W) ? COL_W : MARGIN_W;

   // movement history
   localparam logic [2:0] PH_NONE      = 3'd0;
   localparam logic [2:0] PH_LEFT      = 3'd1;
   localparam logic [2:0] PH_STRAIGHT  = 3'd2;
   localparam logic [2:0] PH_RIGHT     = 3'd3;
   localparam logic [2:0] PH_LEFT_STR  = 3'd4;
   localparam logic [2:0] PH_RIGHT_STR = 3'd5;
   localparam logic [2:0] PH_FAILED    = 3'd6;

   logic [RC_W-1:0]  rows_ff, rows_in;
   logic [RC_W-1:0]  bad_ff, bad_in;
   logic [COL_W-1:0] prev_mid_ff, prev_mid_in;
   logic             have_prev_ff, have_prev_in;
   logic [2:0]       phase_ff, phase_in;

   logic             out_valid_ff, out_valid_in;
   logic [COL_W-1:0] out_mid_ff;
   logic             out_row_valid_ff;
   logic             out_done_ff;
   logic [1:0]       out_shape_ff;

   logic             rec_pattern;
   logic [COL_W-1:0] rec_mid;
   logic             rec_frame_end;
   logic [RC_W-1:0]  rows_next, bad_next;
   logic [COL_W:0]   diff;
   logic [COL_W-1:0] diff_abs;
   logic [1:0]       move;
   logic [2:0]       phase_next;
   logic [PROD_W-1:0] bad_x10, rows_x3p9;
   logic [1:0]       verdict;

   assign {rec_pattern, rec_mid, rec_frame_end} = q_data;
   assign q_pop = !q_status.empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      rows_next = rows_ff;
      if (rows_ff < RC_W'(MAX_ROWS)) begin
         rows_next = rows_ff + 1'b1;
      end
      bad_next = bad_ff;
      if (!rec_pattern && bad_ff < RC_W'(MAX_ROWS)) begin
         bad_next = bad_ff + 1'b1;
      end

      diff     = {1'b0, rec_mid} - {1'b0, prev_mid_ff};
      diff_abs = diff[COL_W] ? COL_W'(-diff) : diff[COL_W-1:0];
      if (CMP_W'(diff_abs) < CMP_W'(margin) || diff == '0) begin
         move = SHAPE_STRAIGHT;
      end else if (!diff[COL_W]) begin
         move = SHAPE_LEFT;
      end else begin
         move = SHAPE_RIGHT;
      end

      phase_next = phase_ff;
      if (rec_pattern && have_prev_ff) begin
         case (phase_ff)
            PH_NONE: begin
               case (move)
                  SHAPE_LEFT:  phase_next = PH_LEFT;
                  SHAPE_RIGHT: phase_next = PH_RIGHT;
                  default:     phase_next = PH_STRAIGHT;
               endcase
            end
            PH_LEFT: begin
               phase_next = (move == SHAPE_LEFT) ? PH_LEFT :
                            (move == SHAPE_STRAIGHT) ? PH_LEFT_STR : PH_FAILED;
            end
            PH_RIGHT: begin
               phase_next = (move == SHAPE_RIGHT) ? PH_RIGHT :
                            (move == SHAPE_STRAIGHT) ? PH_RIGHT_STR : PH_FAILED;
            end
            PH_STRAIGHT: begin
               phase_next = (move == SHAPE_STRAIGHT) ? PH_STRAIGHT : PH_FAILED;
            end
            PH_LEFT_STR, PH_RIGHT_STR: begin
               phase_next = (move == SHAPE_STRAIGHT) ? phase_ff : PH_FAILED;
            end
            default: phase_next = PH_FAILED;
         endcase
      end

      // failed rows at most 30 percent rounded up: 10*bad <= 3*rows + 9
      bad_x10   = PROD_W'(bad_next) * PROD_W'(10);
      rows_x3p9 = PROD_W'(rows_next) * PROD_W'(3) + PROD_W'(9);
      verdict   = SHAPE_NONE;
      if (bad_x10 <= rows_x3p9) begin
         case (phase_next)
            PH_LEFT, PH_LEFT_STR:   verdict = SHAPE_LEFT;
            PH_STRAIGHT:            verdict = SHAPE_STRAIGHT;
            PH_RIGHT, PH_RIGHT_STR: verdict = SHAPE_RIGHT;
            default:                verdict = SHAPE_NONE;
         endcase
      end

      rows_in      = rows_ff;
      bad_in       = bad_ff;
      prev_mid_in  = prev_mid_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      if (q_pop) begin
         if (rec_frame_end) begin
            rows_in      = '0;
            bad_in       = '0;
            prev_mid_in  = '0;
            have_prev_in = 1'b0;
            phase_in     = PH_NONE;
         end else begin
            rows_in  = rows_next;
            bad_in   = bad_next;
            phase_in = phase_next;
            if (rec_pattern) begin
               prev_mid_in  = rec_mid;
               have_prev_in = 1'b1;
            end
         end
      end

      out_valid_in = out_valid_ff && rsp_stall;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= '0;
         bad_ff       <= '0;
         prev_mid_ff  <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= PH_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         bad_ff       <= bad_in;
         prev_mid_ff  <= prev_mid_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_mid_ff       <= rec_mid;
         out_row_valid_ff <= rec_pattern;
         out_done_ff      <= rec_frame_end;
         out_shape_ff     <= rec_frame_end ? verdict : SHAPE_NONE;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_row_midpoint = out_mid_ff;
   assign rsp_row_valid    = out_row_valid_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_shape        = out_shape_ff;

endmodule

FILE: hdl/lane_shape_from_row_runs_unit.sv
// ----------------------------------------------------------------------------
// lane_shape_from_row_runs_unit
// Lane shape estimator on a gray-level pixel stream: per-row run pattern
// check with gray run midpoint, and a per-frame curve verdict.
//
//   channel | ports                     | direction | item
//   --------+---------------------------+-----------+----------------------
//   req     | req_valid / req_stall     | in        | one pixel + row/frame end
//   rsp     | rsp_valid / rsp_stall     | out       | one result per row
//   csr     | csr_wr_en / csr_wr_data   | in        | straight margin
//
// One pixel per cycle while req_stall is low. A row result reaches rsp through
// the record queue, then the output register.
// The two-entry record queue decouples the pixel front end from the output:
// req_stall rises only when that queue is full, i.e. rsp is held stalled.
// Reset is synchronous; the margin returns to 15 and all row and frame
// counters clear. No clearing pass.
// ----------------------------------------------------------------------------
module lane_shape_from_row_runs_unit #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_ROWS  = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_pixel,
   input  logic                             req_row_end,
   input  logic                             req_frame_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [$clog2(MAX_WIDTH)-1:0]     rsp_row_midpoint,
   output logic                             rsp_row_valid,
   output logic                             rsp_frame_done,
   output logic [1:0]                       rsp_shape,
   input  logic                             csr_wr_en,
   input  logic [lsr_pkg::MARGIN_W-1:0]     csr_wr_data
);
   import lsr_pkg::*;

   localparam int unsigned REC_W = $clog2(MAX_WIDTH) + 2;

   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic                req_accept;
   logic                q_push, q_pop;
   logic [REC_W-1:0]    q_push_data, q_pop_data;
   queue_status_type    q_status;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid & !req_stall;
   assign margin_in  = csr_wr_en ? csr_wr_data : margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else begin
         margin_ff <= margin_in;
      end
   end

   lsr_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .pixel     (req_pixel),
      .row_end   (req_row_end),
      .frame_end (req_frame_end),
      .push      (q_push),
      .push_data (q_push_data)
   );

   lsr_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   lsr_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .margin           (margin_ff),
      .q_status         (q_status),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_midpoint (rsp_row_midpoint),
      .rsp_row_valid    (rsp_row_valid),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_shape        (rsp_shape)
   );

   // a finished row is waiting in the queue on the next cycle
   a_row_queued: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_row_end || req_frame_end) |=> !q_status.empty)
      else $error("row record lost after row end");

   // verdict only on the frame's last row
   a_shape_only_at_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_shape == SHAPE_NONE)
      else $error("shape given outside frame end");

   // failed row carries no midpoint
   a_failed_row_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_valid |-> rsp_row_midpoint == '0)
      else $error("midpoint on failed row");

   // queue is drained whenever the output register is free
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !q_status.empty |-> q_pop)
      else $error("queue held while output free");

endmodule

FILE: bench/lane_shape_from_row_runs_unit_tb.sv
// ----------------------------------------------------------------------------
// lane_shape_from_row_runs_unit_tb
// Self-checking bench for the lane shape unit. Streams rows of pixels built
// around the black-white-gray-white-black lane pattern, mixed with noise and
// broken rows. Each row result is checked against a predicted one. Frames
// follow left, right, straight and mixed trends under several margins, with
// random gaps on the pixel side and random stalls on the result side.
// ----------------------------------------------------------------------------
module lane_shape_from_row_runs_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsr_pkg::*;

   localparam int unsigned MAX_WIDTH      = 1024;
   localparam int unsigned MAX_ROWS       = 1024;
   localparam int unsigned MID_W          = $clog2(MAX_WIDTH);
   localparam int unsigned IDLE_PERCENT   = 16;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned NARROW_SPAN    = 16;
   localparam int unsigned WIDE_SPAN      = 40;
   localparam int unsigned PHASES         = 6;
   localparam int unsigned FRAMES_PER_PH  = 2;

   typedef struct packed {
      logic [MID_W-1:0] midpoint;
      logic             row_valid;
      logic             frame_done;
      logic [1:0]       shape;
   } row_result_type;

   // progress of the track through a frame
   typedef enum logic [2:0] {
      PH_NONE, PH_LEFT, PH_STRAIGHT, PH_RIGHT,
      PH_LEFT_STRAIGHT, PH_RIGHT_STRAIGHT, PH_FAILED
   } track_phase_type;

   typedef enum int unsigned {
      TREND_STRAIGHT, TREND_LEFT, TREND_RIGHT,
      TREND_LEFT_THEN_STRAIGHT, TREND_RIGHT_THEN_STRAIGHT, TREND_MIXED
   } trend_type;

   class lane_scoreboard;
      logic [MARGIN_W-1:0] margin;
      int unsigned         column;
      logic [7:0]          last_level;
      int unsigned         run_start;
      logic [1:0]          run_types[4];
      int unsigned         runs_seen;
      bit                  pattern_found;
      bit                  gray_found;
      int unsigned         gray_midpoint;
      int unsigned         row_count;
      int unsigned         invalid_rows;
      int unsigned         prev_midpoint;
      bit                  have_prev;
      track_phase_type     phase;
      row_result_type      expected_q[$];
      int unsigned         errors;
      int unsigned         results_checked;
      int unsigned         verdicts[4];

      function new();
         margin = MARGIN_RESET;
         errors = 0;
         results_checked = 0;
         foreach (verdicts[i]) verdicts[i] = 0;
         clear_row();
         clear_frame();
      endfunction

      function void clear_row();
         column = 0;
         last_level = LEVEL_BLACK;
         run_start = 0;
         foreach (run_types[i]) run_types[i] = TYPE_UNKNOWN;
         runs_seen = 0;
         pattern_found = 0;
         gray_found = 0;
         gray_midpoint = 0;
      endfunction

      function void clear_frame();
         row_count = 0;
         invalid_rows = 0;
         prev_midpoint = 0;
         have_prev = 0;
         phase = PH_NONE;
      endfunction

      function logic [1:0] level_type(logic [7:0] level);
         if (level == LEVEL_BLACK) return TYPE_BLACK;
         if (level == LEVEL_GRAY) return TYPE_GRAY;
         if (level == LEVEL_WHITE) return TYPE_WHITE;
         return TYPE_UNKNOWN;
      endfunction

      function void close_run(logic [1:0] kind, int unsigned s, int unsigned e);
         if (kind == TYPE_GRAY && !gray_found) begin
            gray_found = 1;
            gray_midpoint = (s + e) / 2;
         end
         if (runs_seen >= 4 && run_types[0] == TYPE_BLACK && run_types[1] == TYPE_WHITE &&
             run_types[2] == TYPE_GRAY && run_types[3] == TYPE_WHITE && kind == TYPE_BLACK)
            pattern_found = 1;
         run_types[0] = run_types[1];
         run_types[1] = run_types[2];
         run_types[2] = run_types[3];
         run_types[3] = kind;
         if (runs_seen < 4) runs_seen++;
      endfunction

      function logic [1:0] movement(int d);
         int mag;
         mag = (d < 0) ? -d : d;
         // a zero step is straight even when the margin is zero
         if (mag < int'(margin) || d == 0) return SHAPE_STRAIGHT;
         return (d > 0) ? SHAPE_LEFT : SHAPE_RIGHT;
      endfunction

      function void advance(logic [1:0] mv);
         case (phase)
            PH_NONE: begin
               if (mv == SHAPE_LEFT) phase = PH_LEFT;
               else if (mv == SHAPE_STRAIGHT) phase = PH_STRAIGHT;
               else phase = PH_RIGHT;
            end
            PH_LEFT: begin
               if (mv == SHAPE_STRAIGHT) phase = PH_LEFT_STRAIGHT;
               else if (mv != SHAPE_LEFT) phase = PH_FAILED;
            end
            PH_RIGHT: begin
               if (mv == SHAPE_STRAIGHT) phase = PH_RIGHT_STRAIGHT;
               else if (mv != SHAPE_RIGHT) phase = PH_FAILED;
            end
            PH_STRAIGHT, PH_LEFT_STRAIGHT, PH_RIGHT_STRAIGHT: begin
               if (mv != SHAPE_STRAIGHT) phase = PH_FAILED;
            end
            default: phase = PH_FAILED;
         endcase
      endfunction

      function void note_pixel(logic [7:0] level, bit row_end, bit frame_end);
         int unsigned    col;
         row_result_type r;
         col = column;
         if (col == 0) begin
            run_start = 0;
         end else if (level != last_level) begin
            close_run(level_type(last_level), run_start, col - 1);
            run_start = col;
         end
         last_level = level;
         // frame end closes the row even without row end
         if (!(row_end || frame_end)) begin
            if (column < MAX_WIDTH - 1) column++;
            return;
         end
         close_run(level_type(level), run_start, col);
         r = '0;
         r.row_valid = pattern_found;
         r.midpoint = pattern_found ? gray_midpoint[MID_W-1:0] : '0;
         if (row_count < MAX_ROWS) row_count++;
         if (!pattern_found) begin
            if (invalid_rows < MAX_ROWS) invalid_rows++;
         end else begin
            if (have_prev) advance(movement(int'(r.midpoint) - int'(prev_midpoint)));
            prev_midpoint = r.midpoint;
            have_prev = 1;
         end
         clear_row();
         if (frame_end) begin
            r.frame_done = 1;
            if (invalid_rows <= (3 * row_count + 9) / 10) begin
               case (phase)
                  PH_LEFT, PH_LEFT_STRAIGHT:   r.shape = SHAPE_LEFT;
                  PH_STRAIGHT:                 r.shape = SHAPE_STRAIGHT;
                  PH_RIGHT, PH_RIGHT_STRAIGHT: r.shape = SHAPE_RIGHT;
                  default:                     r.shape = SHAPE_NONE;
               endcase
            end
            clear_frame();
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(row_result_type got);
         row_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected row result: midpoint %0d valid %0b done %0b shape %0d",
                        got.midpoint, got.row_valid, got.frame_done, got.shape);
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got.midpoint !== want.midpoint || got.row_valid !== want.row_valid ||
             got.frame_done !== want.frame_done || got.shape !== want.shape) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("row result %0d: want mid %0d valid %0b done %0b shape %0d,",
                        results_checked, want.midpoint, want.row_valid,
                        want.frame_done, want.shape,
                        " got %0d %0b %0b %0d",
                        got.midpoint, got.row_valid, got.frame_done, got.shape);
         end
         if (want.frame_done) verdicts[want.shape]++;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [7:0]          req_pixel     = '0;
   logic                req_row_end   = 1'b0;
   logic                req_frame_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [MID_W-1:0]    rsp_row_midpoint;
   logic                rsp_row_valid;
   logic                rsp_frame_done;
   logic [1:0]          rsp_shape;
   logic                csr_wr_en     = 1'b0;
   logic [MARGIN_W-1:0] csr_wr_data   = MARGIN_RESET;

   lane_scoreboard lanes = new();
   bit             calm = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    pixels_sent = 0;
   int unsigned    margins_used = 0;
   logic [7:0]     row_buf[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   lane_shape_from_row_runs_unit #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_ROWS (MAX_ROWS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_row_end     (req_row_end),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_midpoint(rsp_row_midpoint),
      .rsp_row_valid   (rsp_row_valid),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_shape       (rsp_shape),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always @(posedge clock) begin : monitor
      row_result_type seen;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            lanes.note_pixel(req_pixel, req_row_end, req_frame_end);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            seen.midpoint = rsp_row_midpoint;
            seen.row_valid = rsp_row_valid;
            seen.frame_done = rsp_frame_done;
            seen.shape = rsp_shape;
            lanes.check_result(seen);
         end
      end
   end

   always @(posedge clock) begin : pacing
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                  idle_cycles, lanes.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic push_pixel(input logic [7:0] level, input bit row_end, input bit frame_end);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel     <= level;
      req_row_end   <= row_end;
      req_frame_end <= frame_end;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // last pixel of a frame may carry frame end alone
   task automatic send_row(input bit last_of_frame, input bit drop_row_end);
      int n;
      n = row_buf.size();
      for (int i = 0; i < n; i++)
         push_pixel(row_buf[i], (i == n - 1) && !(last_of_frame && drop_row_end),
                    (i == n - 1) && last_of_frame);
   endtask

   task automatic write_margin(input logic [MARGIN_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (lanes.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lanes.margin = value;
      margins_used++;
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 4))
         0:       return LEVEL_BLACK;
         1:       return LEVEL_GRAY;
         2:       return LEVEL_WHITE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_run(logic [7:0] level, int unsigned len);
      repeat (len) row_buf.push_back(level);
   endfunction

   // lane row whose gray run starts at gray_start, after some filler
   function automatic void build_lane_row(int unsigned gray_start, int unsigned gray_len);
      int unsigned lead_black, lead_white, filler;
      logic [7:0]  fill_level;
      row_buf.delete();
      lead_black = $urandom_range(1, 3);
      lead_white = $urandom_range(1, 3);
      if (gray_start < lead_black + lead_white) gray_start = lead_black + lead_white;
      filler = gray_start - lead_black - lead_white;
      fill_level = 8'($urandom_range(1, 254));
      for (int i = 0; i < filler; i++)
         row_buf.push_back(($urandom_range(0, 9) == 0) ? pick_level() : fill_level);
      add_run(LEVEL_BLACK, lead_black);
      add_run(LEVEL_WHITE, lead_white);
      add_run(LEVEL_GRAY, gray_len);
      add_run(LEVEL_WHITE, $urandom_range(1, 3));
      add_run(LEVEL_BLACK, $urandom_range(1, 3));
      repeat ($urandom_range(0, 3)) row_buf.push_back(pick_level());
   endfunction

   function automatic void build_noise_row();
      row_buf.delete();
      repeat ($urandom_range(1, 12)) row_buf.push_back(pick_level());
   endfunction

   function automatic void build_any_row(int unsigned gray_start, int unsigned gray_len);
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         build_noise_row();
      end else begin
         build_lane_row(gray_start, gray_len);
         if (kind < 16) row_buf[$urandom_range(0, row_buf.size() - 1)] = pick_level();
      end
   endfunction

   function automatic int step_for(trend_type trend, int unsigned r, int unsigned rows, int m);
      int lo;
      lo = (m > 0) ? m : 1;
      case (trend)
         TREND_LEFT:  return lo + int'($urandom_range(0, 3));
         TREND_RIGHT: return -(lo + int'($urandom_range(0, 3)));
         TREND_LEFT_THEN_STRAIGHT:
            if (r < rows / 2) return lo + int'($urandom_range(0, 3));
         TREND_RIGHT_THEN_STRAIGHT:
            if (r < rows / 2) return -(lo + int'($urandom_range(0, 3)));
         TREND_MIXED: return int'($urandom_range(0, 4 * m + 6)) - (2 * m + 3);
         default: ;
      endcase
      // jitter that stays inside the margin
      return (m == 0) ? 0 : int'($urandom_range(0, 2 * m - 2)) - (m - 1);
   endfunction

   task automatic run_frame(input int unsigned rows, input int unsigned span);
      trend_type   trend;
      int          pos, m;
      int unsigned gray_len;
      m = int'(lanes.margin);
      trend = trend_type'($urandom_range(0, 5));
      gray_len = $urandom_range(1, 6);
      if (trend == TREND_LEFT || trend == TREND_LEFT_THEN_STRAIGHT)
         pos = $urandom_range(2, 2 + span / 4);
      else if (trend == TREND_RIGHT || trend == TREND_RIGHT_THEN_STRAIGHT)
         pos = $urandom_range(span - span / 4, span);
      else
         pos = $urandom_range(2, span);
      for (int unsigned r = 0; r < rows; r++) begin
         build_any_row(pos, gray_len);
         send_row(r == rows - 1, $urandom_range(0, 4) == 0);
         pos += step_for(trend, r, rows, m);
         if (pos < 2) pos = 2;
         if (pos > int'(span)) pos = span;
         if (trend == TREND_MIXED) gray_len = $urandom_range(1, 6);
      end
   endtask

   initial begin : stimulus
      int unsigned margins[PHASES];
      margins = '{0, 3, 1023, 15, $urandom_range(1, 1022), $urandom_range(0, 1023)};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset margin: valid, single-pixel invalid, then frame end alone
      row_buf = {LEVEL_BLACK, LEVEL_WHITE, LEVEL_GRAY, LEVEL_WHITE, LEVEL_BLACK};
      send_row(1'b0, 1'b0);
      row_buf = {8'd200};
      send_row(1'b0, 1'b0);
      row_buf = {LEVEL_BLACK, LEVEL_WHITE, LEVEL_GRAY, LEVEL_WHITE, LEVEL_BLACK};
      send_row(1'b1, 1'b1);
      // frame of one invalid row
      row_buf = {LEVEL_WHITE};
      send_row(1'b1, 1'b0);
      // step equal to the margin
      write_margin(1);
      row_buf = {LEVEL_BLACK, LEVEL_WHITE, LEVEL_GRAY, LEVEL_WHITE, LEVEL_BLACK};
      send_row(1'b0, 1'b0);
      row_buf = {8'd5, LEVEL_BLACK, LEVEL_WHITE, LEVEL_GRAY, LEVEL_WHITE, LEVEL_BLACK};
      send_row(1'b1, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_margin(MARGIN_W'(margins[ph]));
         calm = (ph == 1);
         if (ph == 1) run_frame(3, WIDE_SPAN);
         for (int f = 0; f < FRAMES_PER_PH; f++) begin
            if ($urandom_range(0, 24) == 0) run_frame($urandom_range(2, 3), WIDE_SPAN);
            else run_frame($urandom_range(1, 3), NARROW_SPAN);
         end
      end
      calm = 0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (lanes.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d pixels, %0d row results, %0d margin settings, narrow and wide rows.",
               pixels_sent, lanes.results_checked, margins_used);
      $display("Frame verdicts: %0d none, %0d left, %0d straight, %0d right; %0d errors.",
               lanes.verdicts[SHAPE_NONE], lanes.verdicts[SHAPE_LEFT],
               lanes.verdicts[SHAPE_STRAIGHT], lanes.verdicts[SHAPE_RIGHT], lanes.errors);
      if (lanes.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
